### hdl/edfe_pkg.sv
// ----------------------------------------------------------------------------
// edfe_pkg
// shared types, codes and helpers of the epoch deferred-free engine
// ----------------------------------------------------------------------------
`default_nettype none

package edfe_pkg;

   localparam int MAX_WORKERS_DEF = 8;
   localparam int ENTRY_DEPTH_DEF = 64;
   localparam int EPOCH_DEPTH_DEF = 16;

   localparam int PTR_W   = 64;
   localparam int HEAP_W  = 8;
   localparam int EPOCH_W = 64;
   localparam int CFG_W   = 4;
   localparam int PEND_W  = 7;
   localparam int CSR_W   = 32;
   localparam int PADDR_W = 3;

   // register index of num_workers
   localparam logic CSR_NUM_WORKERS = 1'b0;

   // request kinds
   localparam logic REQ_ENQ  = 1'b0;
   localparam logic REQ_PROC = 1'b1;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_IMM  = 2'd1,
      ACT_REL  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      LOAD_STATUS,
      LOAD_IMM,
      LOAD_REL
   } load_kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ENQ,
      S_CLOSE,
      S_MOD,
      S_SAMPLE,
      S_MIN,
      S_CHECK,
      S_REL,
      S_COMMIT,
      S_RD,
      S_EMIT,
      S_OUT_STAT,
      S_OUT_IMM
   } state_type;

   typedef struct packed {
      logic          accept;
      logic          park;
      logic          close;
      logic          mod_start;
      logic          mod_step;
      logic          sample;
      logic          min_step;
      logic          settle;
      logic          rel_step;
      logic          commit;
      logic          rd;
      logic          emit_adv;
      logic          load;
      load_kind_type load_kind;
   } cmd_type;

   typedef struct packed {
      logic req_is_proc;
      logic park_ok;
      logic batch_empty_next;
      logic mod_done;
      logic sample_eq_safe;
      logic min_done;
      logic min_eq_safe;
      logic rel_more;
      logic total_zero;
      logic emit_last;
      logic out_free;
   } status_type;

   // wrap-safe ordering: a is after b
   function automatic logic is_after(input logic [EPOCH_W-1:0] a,
                                     input logic [EPOCH_W-1:0] b);
      logic [EPOCH_W-1:0] d;
      d = a - b;
      return (d != '0) && !d[EPOCH_W-1];
   endfunction

endpackage

`default_nettype wire

### hdl/epoch_deferred_free_engine_unit.sv
// ----------------------------------------------------------------------------
// epoch_deferred_free_engine_unit
// epoch based deferred-free engine: top level with register port
// ----------------------------------------------------------------------------
// An enqueue beat either frees its pointer at once (barrier held, caller
// not the main thread, or entry ring full) or parks it in the open batch,
// and gives one result beat. A process beat closes the open batch, then
// works out loop_count mod workers four bits a cycle, samples that worker,
// folds the wrap-safe minimum over the workers one per cycle, pops one
// released batch per cycle and finally reads the entry ring once per freed
// entry, one result beat each, held back while the output register is busy;
// it ends early with one status beat when the safe epoch does not move or
// nothing is released. One item is in work at a time; a finished result
// beat sits in an output register, so a new item is taken while it waits.
// num_workers lives at byte address 0.
`default_nettype none

module epoch_deferred_free_engine_unit #(
   parameter int MAX_WORKERS = edfe_pkg::MAX_WORKERS_DEF,
   parameter int ENTRY_DEPTH = edfe_pkg::ENTRY_DEPTH_DEF,
   parameter int EPOCH_DEPTH = edfe_pkg::EPOCH_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // register port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [edfe_pkg::PADDR_W-1:0]   csr_paddr,
   input  wire logic [edfe_pkg::CSR_W-1:0]     csr_pwdata,
   output logic      [edfe_pkg::CSR_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_type,
   input  wire logic [edfe_pkg::PTR_W-1:0]     req_free_ptr_in,
   input  wire logic [edfe_pkg::HEAP_W-1:0]    req_heap_id_in,
   input  wire logic                           req_barrier_held,
   input  wire logic                           req_caller_is_main,
   input  wire logic [edfe_pkg::EPOCH_W-1:0]   req_loop_count,
   input  wire logic [edfe_pkg::EPOCH_W-1:0]   req_worker_epoch,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [1:0]                          rsp_action,
   output logic [edfe_pkg::PTR_W-1:0]          rsp_free_ptr_out,
   output logic [edfe_pkg::HEAP_W-1:0]         rsp_heap_id_out,
   output logic                                rsp_last,
   output logic [edfe_pkg::EPOCH_W-1:0]        rsp_current_epoch_out,
   output logic [edfe_pkg::EPOCH_W-1:0]        rsp_safe_epoch_out,
   output logic [edfe_pkg::PEND_W-1:0]         rsp_pending_total,
   output logic [edfe_pkg::EPOCH_W-1:0]        rsp_enqueued_total,
   output logic [edfe_pkg::EPOCH_W-1:0]        rsp_freed_total
);

   // num_workers register, reset to one worker
   logic [edfe_pkg::CFG_W-1:0] num_workers_ff;
   logic                       csr_hit;

   // register index taken from the word address bit
   assign csr_hit = (csr_paddr[edfe_pkg::PADDR_W-1] == edfe_pkg::CSR_NUM_WORKERS);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_workers_ff <= edfe_pkg::CFG_W'(1);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         num_workers_ff <= csr_pwdata[edfe_pkg::CFG_W-1:0];
      end
   end

   // zero-wait port, reads beyond the register list return zero
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? edfe_pkg::CSR_W'(num_workers_ff) : '0;

   // command and status between sequencer and datapath
   edfe_pkg::cmd_type    cmd;
   edfe_pkg::status_type st;

   edfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   edfe_dp #(
      .MAX_WORKERS (MAX_WORKERS),
      .ENTRY_DEPTH (ENTRY_DEPTH),
      .EPOCH_DEPTH (EPOCH_DEPTH)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cfg_num_workers       (num_workers_ff),
      .req_type              (req_type),
      .req_free_ptr_in       (req_free_ptr_in),
      .req_heap_id_in        (req_heap_id_in),
      .req_barrier_held      (req_barrier_held),
      .req_caller_is_main    (req_caller_is_main),
      .req_loop_count        (req_loop_count),
      .req_worker_epoch      (req_worker_epoch),
      .cmd                   (cmd),
      .st                    (st),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_action            (rsp_action),
      .rsp_free_ptr_out      (rsp_free_ptr_out),
      .rsp_heap_id_out       (rsp_heap_id_out),
      .rsp_last              (rsp_last),
      .rsp_current_epoch_out (rsp_current_epoch_out),
      .rsp_safe_epoch_out    (rsp_safe_epoch_out),
      .rsp_pending_total     (rsp_pending_total),
      .rsp_enqueued_total    (rsp_enqueued_total),
      .rsp_freed_total       (rsp_freed_total)
   );

endmodule

`default_nettype wire

### hdl/edfe_ctrl.sv
// ----------------------------------------------------------------------------
// edfe_ctrl
// sequencer of the deferred-free engine, drives the datapath by commands
// ----------------------------------------------------------------------------
`default_nettype none

module edfe_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire edfe_pkg::status_type st,
   output edfe_pkg::cmd_type        cmd
);

   edfe_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= edfe_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         edfe_pkg::S_IDLE: begin
            if (req_valid) state_in = edfe_pkg::S_DECODE;
         end
         edfe_pkg::S_DECODE: begin
            state_in = st.req_is_proc ? edfe_pkg::S_CLOSE : edfe_pkg::S_ENQ;
         end
         edfe_pkg::S_ENQ: begin
            state_in = st.park_ok ? edfe_pkg::S_OUT_STAT : edfe_pkg::S_OUT_IMM;
         end
         edfe_pkg::S_CLOSE: begin
            state_in = st.batch_empty_next ? edfe_pkg::S_OUT_STAT : edfe_pkg::S_MOD;
         end
         edfe_pkg::S_MOD: begin
            if (st.mod_done) state_in = edfe_pkg::S_SAMPLE;
         end
         edfe_pkg::S_SAMPLE: begin
            state_in = st.sample_eq_safe ? edfe_pkg::S_OUT_STAT : edfe_pkg::S_MIN;
         end
         edfe_pkg::S_MIN: begin
            if (st.min_done) state_in = edfe_pkg::S_CHECK;
         end
         edfe_pkg::S_CHECK: begin
            state_in = st.min_eq_safe ? edfe_pkg::S_OUT_STAT : edfe_pkg::S_REL;
         end
         edfe_pkg::S_REL: begin
            if (!st.rel_more) state_in = edfe_pkg::S_COMMIT;
         end
         edfe_pkg::S_COMMIT: begin
            state_in = st.total_zero ? edfe_pkg::S_OUT_STAT : edfe_pkg::S_RD;
         end
         edfe_pkg::S_RD: begin
            state_in = edfe_pkg::S_EMIT;
         end
         edfe_pkg::S_EMIT: begin
            if (st.out_free) state_in = st.emit_last ? edfe_pkg::S_IDLE : edfe_pkg::S_RD;
         end
         edfe_pkg::S_OUT_STAT, edfe_pkg::S_OUT_IMM: begin
            if (st.out_free) state_in = edfe_pkg::S_IDLE;
         end
         default: begin
            state_in = edfe_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cmd.load_kind = edfe_pkg::LOAD_STATUS;
      case (state_ff)
         edfe_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         edfe_pkg::S_ENQ: begin
            cmd.park = st.park_ok;
         end
         edfe_pkg::S_CLOSE: begin
            cmd.close     = 1'b1;
            cmd.mod_start = 1'b1;
         end
         edfe_pkg::S_MOD: begin
            cmd.mod_step = 1'b1;
         end
         edfe_pkg::S_SAMPLE: begin
            cmd.sample = 1'b1;
         end
         edfe_pkg::S_MIN: begin
            cmd.min_step = 1'b1;
         end
         edfe_pkg::S_CHECK: begin
            cmd.settle = !st.min_eq_safe;
         end
         edfe_pkg::S_REL: begin
            cmd.rel_step = st.rel_more;
         end
         edfe_pkg::S_COMMIT: begin
            cmd.commit = 1'b1;
         end
         edfe_pkg::S_RD: begin
            cmd.rd = 1'b1;
         end
         edfe_pkg::S_EMIT: begin
            cmd.load      = st.out_free;
            cmd.emit_adv  = st.out_free;
            cmd.load_kind = edfe_pkg::LOAD_REL;
         end
         edfe_pkg::S_OUT_STAT: begin
            cmd.load = st.out_free;
         end
         edfe_pkg::S_OUT_IMM: begin
            cmd.load      = st.out_free;
            cmd.load_kind = edfe_pkg::LOAD_IMM;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

### hdl/edfe_dp.sv
// ----------------------------------------------------------------------------
// edfe_dp
// datapath: entry and batch rings, epoch tracking, worker modulo, result beat
// ----------------------------------------------------------------------------
`default_nettype none

module edfe_dp #(
   parameter int MAX_WORKERS = edfe_pkg::MAX_WORKERS_DEF,
   parameter int ENTRY_DEPTH = edfe_pkg::ENTRY_DEPTH_DEF,
   parameter int EPOCH_DEPTH = edfe_pkg::EPOCH_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [edfe_pkg::CFG_W-1:0]   cfg_num_workers,
   input  wire logic                         req_type,
   input  wire logic [edfe_pkg::PTR_W-1:0]   req_free_ptr_in,
   input  wire logic [edfe_pkg::HEAP_W-1:0]  req_heap_id_in,
   input  wire logic                         req_barrier_held,
   input  wire logic                         req_caller_is_main,
   input  wire logic [edfe_pkg::EPOCH_W-1:0] req_loop_count,
   input  wire logic [edfe_pkg::EPOCH_W-1:0] req_worker_epoch,
   input  wire edfe_pkg::cmd_type            cmd,
   output edfe_pkg::status_type              st,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [1:0]                        rsp_action,
   output logic [edfe_pkg::PTR_W-1:0]        rsp_free_ptr_out,
   output logic [edfe_pkg::HEAP_W-1:0]       rsp_heap_id_out,
   output logic                              rsp_last,
   output logic [edfe_pkg::EPOCH_W-1:0]      rsp_current_epoch_out,
   output logic [edfe_pkg::EPOCH_W-1:0]      rsp_safe_epoch_out,
   output logic [edfe_pkg::PEND_W-1:0]       rsp_pending_total,
   output logic [edfe_pkg::EPOCH_W-1:0]      rsp_enqueued_total,
   output logic [edfe_pkg::EPOCH_W-1:0]      rsp_freed_total
);

   localparam int EW     = edfe_pkg::EPOCH_W;
   localparam int EC_W   = $clog2(ENTRY_DEPTH + 1);
   localparam int EI_W   = $clog2(ENTRY_DEPTH);
   localparam int BC_W   = $clog2(EPOCH_DEPTH + 1);
   localparam int BI_W   = $clog2(EPOCH_DEPTH);
   localparam int BS_W   = BC_W + 1;
   localparam int NW_W   = $clog2(MAX_WORKERS + 1);
   localparam int WI_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int CW     = (NW_W > edfe_pkg::CFG_W) ? NW_W : edfe_pkg::CFG_W;
   localparam int MR_W   = NW_W + 1;
   localparam int DIGIT  = 4;
   localparam int MOD_STEPS = EW / DIGIT;
   localparam int MC_W   = $clog2(MOD_STEPS);
   localparam int ENT_W  = edfe_pkg::HEAP_W + edfe_pkg::PTR_W;

   // latched request
   logic                        type_ff;
   logic [edfe_pkg::PTR_W-1:0]  ptr_ff;
   logic [edfe_pkg::HEAP_W-1:0] heap_ff;
   logic                        barrier_ff, main_ff;
   logic [EW-1:0]               loop_ff, wep_ff;

   // engine state
   logic [EI_W-1:0] ehead_ff;
   logic [EC_W-1:0] ecount_ff, open_ff, rem_ff, total_ff, emit_cnt_ff;
   logic [BI_W-1:0] bhead_ff;
   logic [BC_W-1:0] bcount_ff;
   logic [EW-1:0]   cur_ff, safe_ff, minv_ff, recl_ff, enq_ff, freed_ff;
   logic [EW-1:0]   seen_ff [MAX_WORKERS];
   logic [EC_W-1:0] bring [EPOCH_DEPTH];
   logic [ENT_W-1:0] ent_mem [ENTRY_DEPTH];
   logic [ENT_W-1:0] rd_q;
   logic [MR_W-1:0] mod_r_ff;
   logic [MC_W-1:0] mod_cnt_ff;
   logic [WI_W-1:0] min_idx_ff;

   // effective worker count
   logic [CW-1:0]   cfg_ext;
   logic [NW_W-1:0] nw;
   assign cfg_ext = CW'(cfg_num_workers);
   assign nw = (cfg_ext == '0) ? NW_W'(1) :
               (cfg_ext > CW'(MAX_WORKERS)) ? NW_W'(MAX_WORKERS) : NW_W'(cfg_ext);

   // four restoring steps of loop_count mod nw per cycle
   logic [MR_W-1:0] mod_next;
   always_comb begin
      logic [MR_W-1:0] acc;
      acc = mod_r_ff;
      for (int k = 0; k < DIGIT; k++) begin
         acc = {acc[MR_W-2:0], loop_ff[EW-1-k]};
         if (acc >= MR_W'(nw)) acc = acc - MR_W'(nw);
      end
      mod_next = acc;
   end

   logic [WI_W-1:0] w_idx;
   assign w_idx = WI_W'(mod_r_ff);

   // closing the open batch
   logic            close_fire;
   logic [BS_W-1:0] tail_sum, tail_wrap;
   assign close_fire = (open_ff != '0) && (bcount_ff < BC_W'(EPOCH_DEPTH));
   assign tail_sum   = BS_W'(bhead_ff) + BS_W'(bcount_ff);
   assign tail_wrap  = (tail_sum >= BS_W'(EPOCH_DEPTH)) ? tail_sum - BS_W'(EPOCH_DEPTH)
                                                        : tail_sum;

   // parking slot
   logic            park_ok;
   logic [EC_W:0]   slot_sum, slot_wrap;
   assign park_ok   = !barrier_ff && main_ff && (ecount_ff < EC_W'(ENTRY_DEPTH));
   assign slot_sum  = (EC_W+1)'(ehead_ff) + (EC_W+1)'(ecount_ff);
   assign slot_wrap = (slot_sum >= (EC_W+1)'(ENTRY_DEPTH)) ?
                      slot_sum - (EC_W+1)'(ENTRY_DEPTH) : slot_sum;

   // batch release
   logic [EC_W-1:0] sz, take;
   logic            rel_more;
   assign sz       = bring[bhead_ff];
   assign take     = (sz < rem_ff) ? sz : rem_ff;
   assign rel_more = (bcount_ff != '0) && edfe_pkg::is_after(minv_ff, recl_ff);

   logic [BI_W-1:0] bhead_inc;
   logic [EI_W-1:0] ehead_inc;
   assign bhead_inc = (bhead_ff == BI_W'(EPOCH_DEPTH - 1)) ? '0 : bhead_ff + 1'b1;
   assign ehead_inc = (ehead_ff == EI_W'(ENTRY_DEPTH - 1)) ? '0 : ehead_ff + 1'b1;

   logic out_free;
   assign out_free = !rsp_valid || rsp_ready;

   always_comb begin
      st.req_is_proc      = (type_ff == edfe_pkg::REQ_PROC);
      st.park_ok          = park_ok;
      st.batch_empty_next = (bcount_ff == '0) && !close_fire;
      st.mod_done         = (mod_cnt_ff == MC_W'(MOD_STEPS - 1));
      st.sample_eq_safe   = (wep_ff == safe_ff);
      st.min_done         = (NW_W'(min_idx_ff) == nw - 1'b1);
      st.min_eq_safe      = (minv_ff == safe_ff);
      st.rel_more         = rel_more;
      st.total_zero       = (total_ff == '0);
      st.emit_last        = (emit_cnt_ff == EC_W'(1));
      st.out_free         = out_free;
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff    <= req_type;
         ptr_ff     <= req_free_ptr_in;
         heap_ff    <= req_heap_id_in;
         barrier_ff <= req_barrier_held;
         main_ff    <= req_caller_is_main;
         wep_ff     <= req_worker_epoch;
      end
      if (cmd.accept) begin
         loop_ff <= req_loop_count;
      end else if (cmd.mod_step) begin
         loop_ff <= loop_ff << DIGIT;
      end
   end

   // rings without reset
   always_ff @(posedge clock) begin
      if (cmd.park) ent_mem[EI_W'(slot_wrap)] <= {heap_ff, ptr_ff};
      if (cmd.rd) rd_q <= ent_mem[ehead_ff];
      if (cmd.close && close_fire) bring[BI_W'(tail_wrap)] <= open_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ehead_ff    <= '0;
         ecount_ff   <= '0;
         open_ff     <= '0;
         bhead_ff    <= '0;
         bcount_ff   <= '0;
         cur_ff      <= '0;
         safe_ff     <= '0;
         enq_ff      <= '0;
         freed_ff    <= '0;
         minv_ff     <= '0;
         recl_ff     <= '0;
         rem_ff      <= '0;
         total_ff    <= '0;
         emit_cnt_ff <= '0;
         mod_r_ff    <= '0;
         mod_cnt_ff  <= '0;
         min_idx_ff  <= '0;
         for (int i = 0; i < MAX_WORKERS; i++) seen_ff[i] <= '0;
      end else begin
         if (cmd.park) begin
            ecount_ff <= ecount_ff + 1'b1;
            open_ff   <= open_ff + 1'b1;
            enq_ff    <= enq_ff + 1'b1;
         end
         if (cmd.close && close_fire) begin
            bcount_ff <= bcount_ff + 1'b1;
            open_ff   <= '0;
            cur_ff    <= cur_ff + 1'b1;
         end
         if (cmd.mod_start) begin
            mod_r_ff   <= '0;
            mod_cnt_ff <= '0;
         end
         if (cmd.mod_step) begin
            mod_r_ff   <= mod_next;
            mod_cnt_ff <= mod_cnt_ff + 1'b1;
         end
         if (cmd.sample) begin
            seen_ff[w_idx] <= wep_ff;
            minv_ff        <= wep_ff;
            min_idx_ff     <= '0;
         end
         if (cmd.min_step) begin
            if (edfe_pkg::is_after(minv_ff, seen_ff[min_idx_ff])) begin
               minv_ff <= seen_ff[min_idx_ff];
            end
            min_idx_ff <= min_idx_ff + 1'b1;
         end
         if (cmd.settle) begin
            safe_ff  <= minv_ff;
            recl_ff  <= cur_ff - EW'(bcount_ff);
            rem_ff   <= ecount_ff;
            total_ff <= '0;
         end
         if (cmd.rel_step) begin
            rem_ff    <= rem_ff - take;
            total_ff  <= total_ff + take;
            bhead_ff  <= bhead_inc;
            bcount_ff <= bcount_ff - 1'b1;
            recl_ff   <= recl_ff + 1'b1;
         end
         if (cmd.commit) begin
            ecount_ff   <= ecount_ff - total_ff;
            freed_ff    <= freed_ff + EW'(total_ff);
            emit_cnt_ff <= total_ff;
         end
         if (cmd.emit_adv) begin
            ehead_ff    <= ehead_inc;
            emit_cnt_ff <= emit_cnt_ff - 1'b1;
         end
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         case (cmd.load_kind)
            edfe_pkg::LOAD_IMM: begin
               rsp_action       <= edfe_pkg::ACT_IMM;
               rsp_free_ptr_out <= ptr_ff;
               rsp_heap_id_out  <= heap_ff;
               rsp_last         <= 1'b1;
            end
            edfe_pkg::LOAD_REL: begin
               rsp_action       <= edfe_pkg::ACT_REL;
               rsp_free_ptr_out <= rd_q[edfe_pkg::PTR_W-1:0];
               rsp_heap_id_out  <= rd_q[ENT_W-1:edfe_pkg::PTR_W];
               rsp_last         <= (emit_cnt_ff == EC_W'(1));
            end
            default: begin
               rsp_action       <= edfe_pkg::ACT_NONE;
               rsp_free_ptr_out <= '0;
               rsp_heap_id_out  <= '0;
               rsp_last         <= 1'b1;
            end
         endcase
         rsp_current_epoch_out <= cur_ff;
         rsp_safe_epoch_out    <= safe_ff;
         rsp_pending_total     <= edfe_pkg::PEND_W'(ecount_ff);
         rsp_enqueued_total    <= enq_ff;
         rsp_freed_total       <= freed_ff;
      end
   end

`ifndef SYNTHESIS
   a_entry_bound: assert property (@(posedge clock) disable iff (reset)
      ecount_ff <= EC_W'(ENTRY_DEPTH))
      else $error("entry count beyond ring depth");
   a_open_in_ring: assert property (@(posedge clock) disable iff (reset)
      open_ff <= ecount_ff)
      else $error("open batch larger than parked entries");
   a_batch_bound: assert property (@(posedge clock) disable iff (reset)
      bcount_ff <= BC_W'(EPOCH_DEPTH))
      else $error("batch count beyond epoch ring depth");
   a_commit_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> total_ff <= ecount_ff)
      else $error("release larger than parked entries");
`endif

endmodule

`default_nettype wire
